/* rtl/assert_macros.svh */
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

/* rtl/soed_pkg.sv */
package soed_pkg;
    localparam int MAX_OPS_D   = 64;
    localparam int MAX_SITES_D = 1024;
    localparam int FRAC_BITS_D = 24;

    localparam logic [1:0] ACT_CLEAR  = 2'd0;
    localparam logic [1:0] ACT_LOAD   = 2'd1;
    localparam logic [1:0] ACT_EXPAND = 2'd2;

    localparam int ROT_W   = 18;
    localparam int TRANS_W = 26;
    localparam int COORD_W = 32;
    localparam int TYPE_W  = 7;
    localparam int CNT_W   = 7;
    localparam int ACC_W   = 36;

    // controller -> datapath
    typedef struct packed {
        logic op_rd;      // issue table read for current op
        logic compute;    // form the folded site from table data
        logic site_rd;    // issue store read at scan index
        logic store_wr;   // append the site
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic match;      // compared entry is within tolerance
    } t_dp_sts;
endpackage

/* rtl/soed_ram.sv */
module soed_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end
    assign o_rdata = r_rdata;
endmodule

/* rtl/soed_datapath.sv */
module soed_datapath
    import soed_pkg::*;
#(
    parameter int MAX_OPS   = MAX_OPS_D,
    parameter int MAX_SITES = MAX_SITES_D,
    parameter int FRAC_BITS = FRAC_BITS_D
) (
    input  logic                         i_clk,
    input  t_dp_cmd                      i_cmd,
    input  logic                         i_op_we,
    input  logic [$clog2(MAX_OPS)-1:0]   i_op_waddr,
    input  logic [ROT_W+3*TRANS_W-1:0]   i_op_wdata,
    input  logic [$clog2(MAX_OPS)-1:0]   i_op_raddr,
    input  logic [$clog2(MAX_SITES)-1:0] i_site_addr,
    input  logic [COORD_W-1:0]           i_cx,
    input  logic [COORD_W-1:0]           i_cy,
    input  logic [COORD_W-1:0]           i_cz,
    output t_dp_sts                      o_sts,
    output logic [FRAC_BITS:0]           o_fx,
    output logic [FRAC_BITS:0]           o_fy,
    output logic [FRAC_BITS:0]           o_fz
);
    localparam int OPW = ROT_W + 3 * TRANS_W;
    localparam int SW  = FRAC_BITS + 1;
    localparam logic signed [ACC_W-1:0] ONE_Q =
        ACC_W'(64'sd1 <<< FRAC_BITS);
    localparam logic signed [ACC_W-1:0] FTOL =
        ACC_W'(((64'sd1 <<< FRAC_BITS) + 64'sd50000) / 64'sd100000);
    localparam logic signed [SW+1:0] DTOL =
        (SW+2)'(((64'sd1 <<< FRAC_BITS) + 64'sd500) / 64'sd1000);

    logic [OPW-1:0]      w_op;
    logic [3*SW-1:0]     w_site;
    logic [SW-1:0]       r_fx, r_fy, r_fz;

    soed_ram #(.WIDTH(OPW), .DEPTH(MAX_OPS)) u_op_ram (
        .i_clk(i_clk), .i_we(i_op_we), .i_waddr(i_op_waddr),
        .i_wdata(i_op_wdata), .i_raddr(i_op_raddr), .o_rdata(w_op)
    );

    soed_ram #(.WIDTH(3*SW), .DEPTH(MAX_SITES)) u_site_ram (
        .i_clk(i_clk), .i_we(i_cmd.store_wr), .i_waddr(i_site_addr),
        .i_wdata({r_fz, r_fy, r_fx}), .i_raddr(i_site_addr), .o_rdata(w_site)
    );

    function automatic logic signed [ACC_W-1:0] term(
        input logic [1:0] e, input logic [COORD_W-1:0] c);
        logic signed [ACC_W-1:0] v;
        v = ACC_W'($signed(c));
        unique case (e)
            2'd0: term = '0;
            2'd1: term = v;
            2'd2: term = -(v <<< 1);
            default: term = -v;
        endcase
    endfunction

    function automatic logic [SW-1:0] fold(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] neg;
        logic signed [ACC_W-1:0] r;
        neg = -v;
        if (v > ONE_Q) r = v & (ONE_Q - 1);
        else if (v < FTOL && v > -FTOL) r = '0;
        else if (v < 0) r = ONE_Q - (neg & (ONE_Q - 1));
        else if (v > ONE_Q - FTOL) r = ONE_Q;
        else r = v;
        fold = r[SW-1:0];
    endfunction

    function automatic logic signed [ACC_W-1:0] axis(input logic [5:0] r,
        input logic signed [TRANS_W-1:0] t);
        axis = term(r[1:0], i_cx) + term(r[3:2], i_cy) + term(r[5:4], i_cz)
             + ACC_W'(t);
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_cmd.compute) begin
            r_fx <= fold(axis(w_op[5:0], $signed(w_op[ROT_W +: TRANS_W])));
            r_fy <= fold(axis(w_op[11:6], $signed(w_op[ROT_W+TRANS_W +: TRANS_W])));
            r_fz <= fold(axis(w_op[17:12], $signed(w_op[ROT_W+2*TRANS_W +: TRANS_W])));
        end
    end

    function automatic logic near(input logic [SW-1:0] a, input logic [SW-1:0] b);
        logic signed [SW+1:0] d;
        d = $signed({2'b00, a}) - $signed({2'b00, b});
        near = !(d > DTOL || d < -DTOL);
    endfunction

    assign o_sts.match = near(w_site[SW-1:0], r_fx) && near(w_site[SW +: SW], r_fy)
                       && near(w_site[2*SW +: SW], r_fz);
    assign o_fx = r_fx;
    assign o_fy = r_fy;
    assign o_fz = r_fz;
endmodule

/* rtl/soed_ctrl.sv */
module soed_ctrl
    import soed_pkg::*;
#(
    parameter int MAX_OPS   = MAX_OPS_D,
    parameter int MAX_SITES = MAX_SITES_D
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic                         i_clear,
    input  logic [CNT_W-1:0]             i_op_count,
    input  t_dp_sts                      i_sts,
    input  logic                         i_out_ready,
    output t_dp_cmd                      o_cmd,
    output logic                         o_busy,
    output logic [$clog2(MAX_OPS)-1:0]   o_op_addr,
    output logic [$clog2(MAX_SITES)-1:0] o_site_addr,
    output logic                         o_out_valid,
    output logic                         o_is_new,
    output logic                         o_full,
    output logic                         o_last
);
    localparam int OA = $clog2(MAX_OPS);
    localparam int SA = $clog2(MAX_SITES);
    localparam int SC = $clog2(MAX_SITES + 1);
    localparam int OC = $clog2(MAX_OPS + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_OPRD = 3'd1;
    localparam logic [2:0] S_COMP = 3'd2;
    localparam logic [2:0] S_SRD  = 3'd3;
    localparam logic [2:0] S_CMP  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]    r_state, n_state;
    logic [OC-1:0] r_op, n_op, r_nops, n_nops;
    logic [SC-1:0] r_cnt, n_cnt, r_scan, n_scan;
    logic          r_new, n_new, r_fl, n_fl;

    always_comb begin
        n_state = r_state; n_op = r_op; n_nops = r_nops;
        n_cnt = r_cnt; n_scan = r_scan; n_new = r_new; n_fl = r_fl;
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_clear) n_cnt = '0;
                if (i_start) begin
                    n_nops = (i_op_count > CNT_W'(MAX_OPS)) ? OC'(MAX_OPS)
                                                            : OC'(i_op_count);
                    n_op = '0;
                    if (i_op_count != '0) n_state = S_OPRD;
                end
            end
            S_OPRD: begin
                o_cmd.op_rd = 1'b1;
                n_state = S_COMP;
            end
            S_COMP: begin
                o_cmd.compute = 1'b1;
                n_scan = '0;
                n_state = S_SRD;
            end
            S_SRD: begin
                // hold the read address at r_scan; append when scan is done and the store has room
                if (r_scan >= r_cnt) begin
                    if (r_cnt < SC'(MAX_SITES)) begin
                        o_cmd.store_wr = 1'b1;
                        n_cnt = r_cnt + 1'b1;
                        n_new = 1'b1; n_fl = 1'b0;
                    end else begin
                        n_new = 1'b0; n_fl = 1'b1;
                    end
                    n_state = S_OUT;
                end else begin
                    o_cmd.site_rd = 1'b1;
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (i_sts.match) begin
                    n_new = 1'b0; n_fl = 1'b0;
                    n_state = S_OUT;
                end else begin
                    n_scan = r_scan + 1'b1;
                    n_state = S_SRD;
                end
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_op = r_op + 1'b1;
                    n_state = (r_op + 1'b1 == r_nops) ? S_IDLE : S_OPRD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_cnt <= '0; r_op <= '0; r_nops <= '0;
            r_scan <= '0; r_new <= 1'b0; r_fl <= 1'b0;
        end else begin
            r_state <= n_state; r_cnt <= n_cnt; r_op <= n_op; r_nops <= n_nops;
            r_scan <= n_scan; r_new <= n_new; r_fl <= n_fl;
        end
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_op_addr   = r_op[OA-1:0];
    assign o_site_addr = (r_scan >= r_cnt) ? r_cnt[SA-1:0] : r_scan[SA-1:0];
    assign o_out_valid = (r_state == S_OUT);
    assign o_is_new    = r_new;
    assign o_full      = r_fl;
    assign o_last      = (r_op + 1'b1 == r_nops);
endmodule

/* rtl/symmetry_orbit_expand_dedup_core.sv */
// Channel   Dir  Handshake                Contents
// s_axis    in   i_s_axis_tvalid/tready   action in tuser; op, translation, atom
// m_axis    out  o_m_axis_tvalid/tready   one folded site per operation, flags in tuser
// cfg       in   i_cfg_valid/o_cfg_ready  op_count
//
// Clear and load are applied as they are accepted. An expand runs, per
// operation, a table read and a fold, then for each stored site scanned
// a read of the single-port site RAM and a compare, then an output state.
// Reset is synchronous, active low; it empties the site store by zeroing
// the count, no clearing pass. A stalled output holds the controller in
// its output state.
`include "assert_macros.svh"
module symmetry_orbit_expand_dedup_core
    import soed_pkg::*;
#(
    parameter int MAX_OPS   = MAX_OPS_D,
    parameter int MAX_SITES = MAX_SITES_D,
    parameter int FRAC_BITS = FRAC_BITS_D
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // action[1:0]
    input  logic [1:0]   i_s_axis_tuser,
    // op_index[5:0], rotation_packed[23:6], trans_x[49:24], trans_y[75:50],
    // trans_z[101:76], atom_type[108:102], coord_x[140:109],
    // coord_y[172:141], coord_z[204:173], zero fill to 208
    input  logic [207:0] i_s_axis_tdata,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [6:0]   i_cfg_data,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // site_type[6:0], site_x, site_y, site_z, zero fill to whole bytes
    output logic [7+3*(FRAC_BITS+1)+((8-((7+3*(FRAC_BITS+1))%8))%8)-1:0]
                         o_m_axis_tdata,
    // is_new[0], store_full[1]
    output logic [1:0]   o_m_axis_tuser,
    output logic         o_m_axis_tlast
);
    localparam int SW  = FRAC_BITS + 1;
    localparam int OW  = 7 + 3 * SW;
    localparam int TDW = OW + (8 - OW % 8) % 8;
    localparam int OA  = $clog2(MAX_OPS);
    localparam int SA  = $clog2(MAX_SITES);

    logic [1:0]        w_act;
    logic [5:0]        w_idx;
    logic              w_acc;
    logic              w_busy;
    t_dp_cmd           w_cmd;
    t_dp_sts           w_sts;
    logic [OA-1:0]     w_op_addr;
    logic [SA-1:0]     w_site_addr;
    logic [SW-1:0]     w_fx, w_fy, w_fz;
    logic              w_new, w_full, w_last;
    logic [CNT_W-1:0]  r_op_count;
    logic [TYPE_W-1:0] r_type;
    logic [COORD_W-1:0] r_cx, r_cy, r_cz;

    assign w_act = i_s_axis_tuser;
    assign w_idx = i_s_axis_tdata[5:0];
    assign o_s_axis_tready = !w_busy;
    assign o_cfg_ready = !w_busy;
    assign w_acc = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op_count <= CNT_W'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_op_count <= i_cfg_data;
        end
    end

    // hold atom payload for the whole expansion
    always_ff @(posedge i_clk) begin
        if (w_acc && w_act == ACT_EXPAND) begin
            r_type <= i_s_axis_tdata[108:102];
            r_cx   <= i_s_axis_tdata[140:109];
            r_cy   <= i_s_axis_tdata[172:141];
            r_cz   <= i_s_axis_tdata[204:173];
        end
    end

    soed_ctrl #(.MAX_OPS(MAX_OPS), .MAX_SITES(MAX_SITES)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_start(w_acc && w_act == ACT_EXPAND),
        .i_clear(w_acc && w_act == ACT_CLEAR),
        .i_op_count(r_op_count), .i_sts(w_sts),
        .i_out_ready(i_m_axis_tready), .o_cmd(w_cmd), .o_busy(w_busy),
        .o_op_addr(w_op_addr), .o_site_addr(w_site_addr),
        .o_out_valid(o_m_axis_tvalid), .o_is_new(w_new), .o_full(w_full),
        .o_last(w_last)
    );

    soed_datapath #(.MAX_OPS(MAX_OPS), .MAX_SITES(MAX_SITES),
                    .FRAC_BITS(FRAC_BITS)) u_dp (
        .i_clk(i_clk), .i_cmd(w_cmd),
        // drop loads to slots beyond the table
        .i_op_we(w_acc && w_act == ACT_LOAD && 32'(w_idx) < MAX_OPS),
        .i_op_waddr(w_idx[OA-1:0]),
        .i_op_wdata(i_s_axis_tdata[101:6]),
        .i_op_raddr(w_op_addr), .i_site_addr(w_site_addr),
        .i_cx(r_cx), .i_cy(r_cy), .i_cz(r_cz),
        .o_sts(w_sts), .o_fx(w_fx), .o_fy(w_fy), .o_fz(w_fz)
    );

    assign o_m_axis_tdata = TDW'({w_fz, w_fy, w_fx, r_type});
    assign o_m_axis_tuser = {w_full, w_new};
    assign o_m_axis_tlast = w_last;

    `ASSERT_NEVER(a_new_full, i_clk, i_rst_n, o_m_axis_tvalid && w_new && w_full, "new and full together")
    `ASSERT_NEVER(a_acc_busy, i_clk, i_rst_n, w_acc && w_busy, "input taken while busy")
    `ASSERT_CLK(a_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser), "result lost under stall")
endmodule
